// ===== rtl/core/stq_pkg.sv =====
package stq_pkg;

    localparam int CMD_W      = 3;
    localparam int TIME_W     = 48;
    localparam int AGENT_W    = 16;
    localparam int PERIOD_W   = 31;
    localparam int DATA_W     = 32;
    localparam int ID_W       = 31;
    localparam int STATUS_W   = 2;
    localparam int WAIT_W     = 32;
    localparam int PROD_W     = 41;
    localparam int REM_W      = 10;

    localparam int DEFAULT_DEPTH = 16;

    localparam logic [REM_W-1:0]  USEC_PER_MS = 10'd1000;
    localparam logic [WAIT_W-1:0] MAX_WAIT    = 32'h7FFF_FFFF;
    localparam logic [WAIT_W-1:0] WAIT_EMPTY  = 32'hFFFF_FFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_START        = 3'd0,
        CMD_CANCEL_ID    = 3'd1,
        CMD_CANCEL_AGENT = 3'd2,
        CMD_CANCEL_DATA  = 3'd3,
        CMD_ACTIVE       = 3'd4,
        CMD_TIME_NEXT    = 3'd5,
        CMD_TAKE         = 3'd6,
        CMD_PEEK         = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_AGENT = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD,
        S_INS_SCAN,
        S_FIND,
        S_AGENT,
        S_DIV,
        S_POLL_SCAN,
        S_POLL_END,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        TBL_NOP,
        TBL_INSERT,
        TBL_DELETE,
        TBL_MARK
    } tbl_kind_t;

    typedef struct packed {
        logic [TIME_W-1:0]  deadline;
        logic [ID_W-1:0]    id;
        logic [AGENT_W-1:0] agent;
        logic [DATA_W-1:0]  data;
        logic               expired;
    } entry_t;

    typedef struct packed {
        tbl_kind_t kind;
        entry_t    ent;
    } tbl_op_t;

endpackage

// ===== rtl/core/stq_table.sv =====
module stq_table
    import stq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH,
    localparam int IDXW = $clog2(DEPTH),
    localparam int CNTW = $clog2(DEPTH + 1)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  tbl_op_t         op,
    input  logic [IDXW-1:0] pos,
    input  logic [IDXW-1:0] rd_idx,
    output entry_t          rd_ent,
    output entry_t          head_ent,
    output logic [CNTW-1:0] count
);

    entry_t          ent_reg [DEPTH];
    logic [CNTW-1:0] count_reg;

    assign rd_ent   = ent_reg[rd_idx];
    assign head_ent = ent_reg[0];
    assign count    = count_reg;

    // Inserts and deletes move every entry at or past the position by one slot.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            unique case (op.kind)
                TBL_INSERT:
                begin
                    if (IDXW'(j) == pos)
                    begin
                        ent_reg[j] <= op.ent;
                    end
                    else if (j > 0 && IDXW'(j) > pos)
                    begin
                        ent_reg[j] <= ent_reg[(j > 0) ? j - 1 : 0];
                    end
                end
                TBL_DELETE:
                begin
                    if (j < DEPTH - 1 && IDXW'(j) >= pos)
                    begin
                        ent_reg[j] <= ent_reg[(j < DEPTH - 1) ? j + 1 : j];
                    end
                end
                TBL_MARK:
                begin
                    if (IDXW'(j) == pos)
                    begin
                        ent_reg[j].expired <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (op.kind == TBL_INSERT)
        begin
            count_reg <= count_reg + CNTW'(1);
        end
        else if (op.kind == TBL_DELETE)
        begin
            count_reg <= count_reg - CNTW'(1);
        end
    end

endmodule

// ===== rtl/core/stq_div.sv =====
module stq_div
    import stq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] dividend,
    output logic              done,
    output logic [TIME_W-1:0] quotient
);

    localparam int NUM_W   = 38;
    localparam int HALF_W  = 19;
    localparam int RLO_W   = 20;
    localparam int RECIP_W = 39;
    localparam int MUL_W   = HALF_W + RLO_W;
    localparam int ACC_W   = NUM_W + RECIP_W;
    localparam int SHIFT   = 45;
    localparam int SAT_BIT = 41;

    // Rounded-up 2^45/125. The three low dividend bits are dropped first, since x/1000
    // equals (x/8)/125. A dividend of 2^41 or more always saturates the wait.
    localparam logic [RECIP_W-1:0] RECIP = 39'h41_8937_4BC7;

    logic [NUM_W-1:0]  num_reg;
    logic              sat_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [2:0]        step_reg;
    logic              run_reg;
    logic [HALF_W-1:0] mul_a;
    logic [RLO_W-1:0]  mul_b;
    logic [MUL_W-1:0]  mul_p;
    logic [ACC_W-1:0]  term;

    // One 19x20 multiplier forms the four partial products in turn.
    assign mul_p    = MUL_W'(mul_a) * MUL_W'(mul_b);
    assign done     = run_reg && step_reg[2];
    assign quotient = sat_reg ? '1 : TIME_W'(acc_reg[ACC_W-1:SHIFT]);

    always_comb
    begin
        unique case (step_reg[1:0])
            2'd0:
            begin
                mul_a = num_reg[HALF_W-1:0];
                mul_b = RECIP[RLO_W-1:0];
            end
            2'd1:
            begin
                mul_a = num_reg[HALF_W-1:0];
                mul_b = RLO_W'(RECIP[RECIP_W-1:RLO_W]);
            end
            2'd2:
            begin
                mul_a = num_reg[NUM_W-1:HALF_W];
                mul_b = RECIP[RLO_W-1:0];
            end
            2'd3:
            begin
                mul_a = num_reg[NUM_W-1:HALF_W];
                mul_b = RLO_W'(RECIP[RECIP_W-1:RLO_W]);
            end
        endcase
    end

    always_comb
    begin
        unique case (step_reg[1:0])
            2'd0:    term = ACC_W'(mul_p);
            2'd1:    term = ACC_W'(mul_p) << RLO_W;
            2'd2:    term = ACC_W'(mul_p) << HALF_W;
            2'd3:    term = ACC_W'(mul_p) << (HALF_W + RLO_W);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend[SAT_BIT-1:3];
            sat_reg <= |dividend[TIME_W-1:SAT_BIT];
            acc_reg <= '0;
        end
        else if (run_reg && !step_reg[2])
        begin
            acc_reg <= acc_reg + term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            step_reg <= '0;
        end
        else if (run_reg)
        begin
            if (step_reg[2])
            begin
                run_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg + 3'd1;
            end
        end
    end

endmodule

// ===== rtl/core/sorted_timeout_queue.sv =====
// Each transaction passes an accept state, a dispatch state and a command walk;
// time to next does the divide by 1000 as a reciprocal multiply on one shared
// 19x20 multiplier.
// One transaction is in work at a time; req_stall is high until the result is taken.
// rst_n clears the entry count, the sequencer and the id counter (next id is 1).
module sorted_timeout_queue
    import stq_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [TIME_W-1:0]   now_us,
    input  logic [AGENT_W-1:0]  agent_id,
    input  logic [PERIOD_W-1:0] period_ms,
    input  logic signed [DATA_W-1:0] agent_data,
    input  logic [ID_W-1:0]     timer_ref,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     result_id,
    output logic [AGENT_W-1:0]  result_agent,
    output logic signed [DATA_W-1:0] result_data,
    output logic                hit,
    output logic signed [WAIT_W-1:0] wait_ms
);

    localparam int IDXW = $clog2(TABLE_DEPTH);
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);

    state_t state_reg, state_next;

    cmd_t                cmd_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [AGENT_W-1:0]  agent_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [DATA_W-1:0]   data_reg;
    logic [ID_W-1:0]     ref_reg;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [TIME_W-1:0]   dl_reg, dl_next;
    logic [CNTW-1:0]     k_reg, k_next;
    logic                eq_reg, eq_next;
    logic                eqexp_reg, eqexp_next;
    logic [ID_W-1:0]     next_id_reg, next_id_next;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ID_W-1:0]     rid_reg, rid_next;
    logic [AGENT_W-1:0]  ragent_reg, ragent_next;
    logic [DATA_W-1:0]   rdata_reg, rdata_next;
    logic                hit_reg, hit_next;
    logic [WAIT_W-1:0]   wait_reg, wait_next;

    tbl_op_t         tbl_op;
    logic [IDXW-1:0] tbl_pos;
    entry_t          rd_ent;
    entry_t          head_ent;
    logic [CNTW-1:0] count;

    logic              div_start;
    logic              div_done;
    logic [TIME_W-1:0] div_quo;

    logic              accept;
    logic              in_range;
    logic [TIME_W:0]   dl_sum;
    logic [ID_W-1:0]   new_id;

    assign accept   = req_valid && !req_stall;
    assign in_range = k_reg < count;
    assign dl_sum   = {1'b0, now_reg} + (TIME_W + 1)'(prod_reg);
    assign new_id   = (next_id_reg == '0) ? ID_W'(1) : next_id_reg;

    assign req_stall    = state_reg != S_IDLE;
    assign rsp_valid    = state_reg == S_DONE;
    assign status       = status_reg;
    assign result_id    = rid_reg;
    assign result_agent = ragent_reg;
    assign result_data  = rdata_reg;
    assign hit          = hit_reg;
    assign wait_ms      = wait_reg;

    stq_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (tbl_op),
        .pos      (tbl_pos),
        .rd_idx   (k_reg[IDXW-1:0]),
        .rd_ent   (rd_ent),
        .head_ent (head_ent),
        .count    (count)
    );

    stq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (head_ent.deadline - now_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (cmd_reg)
                    CMD_START:
                    begin
                        if (agent_reg == '0 || count == CNTW'(TABLE_DEPTH))
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_ADD;
                        end
                    end
                    CMD_CANCEL_ID, CMD_ACTIVE:
                    begin
                        state_next = (ref_reg == '0) ? S_DONE : S_FIND;
                    end
                    CMD_CANCEL_AGENT, CMD_CANCEL_DATA:
                    begin
                        state_next = (agent_reg == '0) ? S_DONE : S_AGENT;
                    end
                    CMD_TIME_NEXT:
                    begin
                        if (count == '0 || head_ent.deadline < now_reg)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_DIV;
                        end
                    end
                    CMD_TAKE, CMD_PEEK:
                    begin
                        if (count == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else if (head_ent.expired)
                        begin
                            state_next = S_POLL_END;
                        end
                        else
                        begin
                            state_next = S_POLL_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_ADD:
            begin
                state_next = S_INS_SCAN;
            end
            S_INS_SCAN:
            begin
                if (!(in_range && dl_reg >= rd_ent.deadline))
                begin
                    state_next = S_DONE;
                end
            end
            S_FIND:
            begin
                if (!in_range || rd_ent.id == ref_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_AGENT:
            begin
                if (!in_range)
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_POLL_SCAN:
            begin
                if (!(in_range && now_reg >= rd_ent.deadline))
                begin
                    state_next = S_POLL_END;
                end
            end
            S_POLL_END:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        prod_next    = prod_reg;
        dl_next      = dl_reg;
        k_next       = k_reg;
        eq_next      = eq_reg;
        eqexp_next   = eqexp_reg;
        next_id_next = next_id_reg;
        status_next  = status_reg;
        rid_next     = rid_reg;
        ragent_next  = ragent_reg;
        rdata_next   = rdata_reg;
        hit_next     = hit_reg;
        wait_next    = wait_reg;
        tbl_op.kind  = TBL_NOP;
        tbl_op.ent   = '0;
        tbl_pos      = k_reg[IDXW-1:0];
        div_start    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    rid_next    = '0;
                    ragent_next = '0;
                    rdata_next  = '0;
                    hit_next    = 1'b0;
                    wait_next   = '0;
                    k_next      = '0;
                    eq_next     = 1'b0;
                    eqexp_next  = 1'b0;
                end
            end
            S_DISPATCH:
            begin
                prod_next = PROD_W'(period_reg) * PROD_W'(USEC_PER_MS);
                unique case (cmd_reg)
                    CMD_START:
                    begin
                        if (agent_reg == '0)
                        begin
                            status_next = ST_BAD_AGENT;
                        end
                        else if (count == CNTW'(TABLE_DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    CMD_CANCEL_AGENT, CMD_CANCEL_DATA:
                    begin
                        if (agent_reg == '0)
                        begin
                            status_next = ST_BAD_AGENT;
                        end
                    end
                    CMD_TIME_NEXT:
                    begin
                        if (count == '0)
                        begin
                            wait_next = WAIT_EMPTY;
                        end
                        else if (!(head_ent.deadline < now_reg))
                        begin
                            div_start = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_ADD:
            begin
                dl_next      = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];
                rid_next     = new_id;
                next_id_next = new_id + ID_W'(1);
            end
            S_INS_SCAN:
            begin
                if (in_range && dl_reg >= rd_ent.deadline)
                begin
                    eq_next    = rd_ent.deadline == dl_reg;
                    eqexp_next = rd_ent.expired;
                    k_next     = k_reg + CNTW'(1);
                end
                else
                begin
                    // Period 0 marks it; else equal predecessor's mark, else successor's.
                    tbl_op.kind         = TBL_INSERT;
                    tbl_op.ent.deadline = dl_reg;
                    tbl_op.ent.id       = rid_reg;
                    tbl_op.ent.agent    = agent_reg;
                    tbl_op.ent.data     = data_reg;
                    if (period_reg == '0)
                    begin
                        tbl_op.ent.expired = 1'b1;
                    end
                    else if (eq_reg)
                    begin
                        tbl_op.ent.expired = eqexp_reg;
                    end
                    else
                    begin
                        tbl_op.ent.expired = in_range && rd_ent.expired;
                    end
                end
            end
            S_FIND:
            begin
                if (in_range)
                begin
                    if (rd_ent.id == ref_reg)
                    begin
                        if (cmd_reg == CMD_CANCEL_ID)
                        begin
                            tbl_op.kind = TBL_DELETE;
                        end
                        else
                        begin
                            hit_next = 1'b1;
                        end
                    end
                    else
                    begin
                        k_next = k_reg + CNTW'(1);
                    end
                end
            end
            S_AGENT:
            begin
                if (in_range)
                begin
                    if (rd_ent.agent == agent_reg &&
                        (cmd_reg == CMD_CANCEL_AGENT || rd_ent.data == data_reg))
                    begin
                        tbl_op.kind = TBL_DELETE;
                    end
                    else
                    begin
                        k_next = k_reg + CNTW'(1);
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    wait_next = (div_quo > TIME_W'(MAX_WAIT)) ? MAX_WAIT : div_quo[WAIT_W-1:0];
                end
            end
            S_POLL_SCAN:
            begin
                if (in_range && now_reg >= rd_ent.deadline)
                begin
                    tbl_op.kind = TBL_MARK;
                    k_next      = k_reg + CNTW'(1);
                end
            end
            S_POLL_END:
            begin
                tbl_pos = '0;
                if (head_ent.expired)
                begin
                    hit_next    = 1'b1;
                    rid_next    = head_ent.id;
                    ragent_next = head_ent.agent;
                    rdata_next  = head_ent.data;
                    if (cmd_reg == CMD_TAKE)
                    begin
                        tbl_op.kind = TBL_DELETE;
                    end
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_t'(cmd);
            now_reg    <= now_us;
            agent_reg  <= agent_id;
            period_reg <= period_ms;
            data_reg   <= agent_data;
            ref_reg    <= timer_ref;
        end
        prod_reg   <= prod_next;
        dl_reg     <= dl_next;
        k_reg      <= k_next;
        eq_reg     <= eq_next;
        eqexp_reg  <= eqexp_next;
        status_reg <= status_next;
        rid_reg    <= rid_next;
        ragent_reg <= ragent_next;
        rdata_reg  <= rdata_next;
        hit_reg    <= hit_next;
        wait_reg   <= wait_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            next_id_reg <= ID_W'(1);
        end
        else
        begin
            state_reg   <= state_next;
            next_id_reg <= next_id_next;
        end
    end

endmodule
